// File: rtl/fcw_pkg.sv
// Shared constants, codes and control types for the FAT12 cluster chain walker.
package fcw_pkg;

	// Allocation table size in bytes (a power of two) and its address width
	localparam int TABLE_BYTES = 8192;
	localparam int TABLE_AW    = $clog2(TABLE_BYTES);

	// Field widths
	localparam int FUNC_W    = 2;
	localparam int INDEX_W   = 13;
	localparam int BYTE_W    = 8;
	localparam int CLUSTER_W = 12;
	localparam int SECTOR_W  = 7;
	localparam int LBA_W     = 32;
	localparam int SPC_W     = 8;
	localparam int PROD_W    = CLUSTER_W + 1 + SPC_W + 1;

	// Chain constants
	localparam logic [CLUSTER_W-1:0] END_MARK           = 12'hFF8;
	localparam logic [CLUSTER_W:0]   FIRST_DATA_CLUSTER = 13'd2;
	localparam logic [SPC_W-1:0]     SPC_MIN            = 8'd1;
	localparam logic [SPC_W-1:0]     SPC_MAX            = 8'd128;

	// Input item kinds
	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_DATA_START_LBA      = 1'b0;
	localparam logic CFG_SECTORS_PER_CLUSTER = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic ram_wr;       // store the table byte of a load
		logic chain_start;  // load the start cluster
		logic sector_step;  // advance the sector index, wrap at cluster end
		logic addr_hi;      // read the upper byte of the table entry
		logic lo_capture;   // keep the lower byte of the table entry
		logic entry_load;   // move to the cluster read from the table
		logic prod_load;    // register the cluster offset product
		logic out_load;     // load the result register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic ended;        // chain has hit an end marker
		logic wrap;         // next sector leaves the current cluster
		logic out_free;     // result register can take a new result
	} stat_t;

endpackage

// File: rtl/fcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: rtl/fcw_datapath.sv
// Datapath: chain state, configuration registers, table memory, address math, result register.
module fcw_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fcw_pkg::cmd_t                cmd,
	output fcw_pkg::stat_t               stat,
	input  logic                         cfg_valid,
	input  logic                         cfg_index,
	input  logic [fcw_pkg::LBA_W-1:0]    cfg_data,
	input  logic [fcw_pkg::INDEX_W-1:0]  table_index,
	input  logic [fcw_pkg::BYTE_W-1:0]   table_byte,
	input  logic [fcw_pkg::CLUSTER_W-1:0] start_cluster,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [fcw_pkg::LBA_W-1:0]    sector_lba,
	output logic                         chain_ended,
	output logic [fcw_pkg::CLUSTER_W-1:0] cluster_now,
	output logic [fcw_pkg::SECTOR_W-1:0] sector_in_cluster
);
	import fcw_pkg::*;

	logic [LBA_W-1:0]     data_start_q;
	logic [SPC_W-1:0]     spc_q;
	logic [SPC_W-1:0]     spc_eff;
	logic [CLUSTER_W-1:0] cluster_q;
	logic [SECTOR_W-1:0]  sidx_q;
	logic                 ended_q;
	logic [SECTOR_W:0]    sidx_next;
	logic [INDEX_W-1:0]   entry_pos;
	logic [INDEX_W-1:0]   rd_pos;
	logic [TABLE_AW-1:0]  rd_addr;
	logic [TABLE_AW-1:0]  wr_addr;
	logic                 wr_en;
	logic [BYTE_W-1:0]    rd_data;
	logic [BYTE_W-1:0]    lo_q;
	logic [2*BYTE_W-1:0]  entry_word;
	logic [CLUSTER_W-1:0] entry;
	logic signed [CLUSTER_W:0] cl_off;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_q;
	logic [LBA_W-1:0]     lba_sum;
	logic                 out_valid_q;
	logic [LBA_W-1:0]     lba_q;
	logic                 ended_out_q;
	logic [CLUSTER_W-1:0] cluster_out_q;
	logic [SECTOR_W-1:0]  sidx_out_q;

	// Configuration registers, written whenever the port transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= '0;
			spc_q        <= SPC_MIN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DATA_START_LBA:      data_start_q <= cfg_data;
				CFG_SECTORS_PER_CLUSTER: spc_q        <= cfg_data[SPC_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp sectors per cluster to 1..128
	always_comb begin
		if (spc_q == '0) begin
			spc_eff = SPC_MIN;
		end else if (spc_q > SPC_MAX) begin
			spc_eff = SPC_MAX;
		end else begin
			spc_eff = spc_q;
		end
	end

	assign sidx_next = {1'b0, sidx_q} + 1'b1;

	// Table memory: loads beyond the table are dropped
	assign wr_en     = cmd.ram_wr && ({1'b0, table_index} < (INDEX_W + 1)'(TABLE_BYTES));
	assign wr_addr   = table_index[TABLE_AW-1:0];
	assign entry_pos = {1'b0, cluster_q} + {2'b00, cluster_q[CLUSTER_W-1:1]};
	assign rd_pos    = cmd.addr_hi ? entry_pos + 1'b1 : entry_pos;
	assign rd_addr   = rd_pos[TABLE_AW-1:0];

	fcw_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TABLE_BYTES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (table_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Hold the lower entry byte until the upper one arrives
	always_ff @(posedge clk) begin
		if (cmd.lo_capture) begin
			lo_q <= rd_data;
		end
	end

	// Pick the 12-bit entry: even clusters take the low bits, odd ones shift by four
	assign entry_word = {rd_data, lo_q};
	assign entry      = cluster_q[0] ? entry_word[2*BYTE_W-1:4] : entry_word[CLUSTER_W-1:0];

	// Chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_q <= '0;
			sidx_q    <= '0;
			ended_q   <= 1'b1;
		end else begin
			if (cmd.chain_start) begin
				cluster_q <= start_cluster;
				sidx_q    <= '0;
				ended_q   <= (start_cluster >= END_MARK);
			end
			if (cmd.sector_step) begin
				sidx_q <= stat.wrap ? '0 : sidx_next[SECTOR_W-1:0];
			end
			if (cmd.entry_load) begin
				cluster_q <= entry;
				ended_q   <= (entry >= END_MARK);
			end
		end
	end

	// Cluster offset times sectors per cluster, signed so clusters zero and one wrap
	assign cl_off = $signed({1'b0, cluster_q}) - $signed(FIRST_DATA_CLUSTER);
	assign prod   = cl_off * $signed({1'b0, spc_eff});

	always_ff @(posedge clk) begin
		if (cmd.prod_load) begin
			prod_q <= prod;
		end
	end

	assign lba_sum = data_start_q + LBA_W'(prod_q) + LBA_W'(sidx_q);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			lba_q         <= ended_q ? '0 : lba_sum;
			ended_out_q   <= ended_q;
			cluster_out_q <= cluster_q;
			sidx_out_q    <= sidx_q;
		end
	end

	// Status to the controller
	assign stat.ended    = ended_q;
	assign stat.wrap     = (sidx_next >= spc_eff);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign sector_lba        = lba_q;
	assign chain_ended       = ended_out_q;
	assign cluster_now       = cluster_out_q;
	assign sector_in_cluster = sidx_out_q;

endmodule

// File: rtl/fcw_ctrl.sv
// Controller: sequences loads, starts and advances through the datapath.
module fcw_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [fcw_pkg::FUNC_W-1:0] func,
	input  fcw_pkg::stat_t            stat,
	output fcw_pkg::cmd_t             cmd
);
	import fcw_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD_LO = 3'd1;
	localparam logic [2:0] ST_RD_HI = 3'd2;
	localparam logic [2:0] ST_ENTRY = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_LOAD: begin
							cmd.ram_wr = 1'b1;
						end
						FUNC_START: begin
							cmd.chain_start = 1'b1;
							state_next      = ST_MUL;
						end
						FUNC_ADVANCE: begin
							if (stat.ended) begin
								state_next = ST_MUL;
							end else begin
								cmd.sector_step = 1'b1;
								state_next      = stat.wrap ? ST_RD_LO : ST_MUL;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RD_LO: begin
				state_next = ST_RD_HI;
			end
			ST_RD_HI: begin
				cmd.addr_hi    = 1'b1;
				cmd.lo_capture = 1'b1;
				state_next     = ST_ENTRY;
			end
			ST_ENTRY: begin
				cmd.entry_load = 1'b1;
				state_next     = ST_MUL;
			end
			ST_MUL: begin
				cmd.prod_load = 1'b1;
				state_next    = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// File: rtl/fat12_cluster_chain_sector_walker_top.sv
// Top level of the FAT12 cluster chain sector walker.
//
// Input stream (s_axis): tuser carries the item kind (load table byte, start
// chain, advance one sector); tdata carries table index, table byte and start
// cluster. A load writes one byte of the allocation table and gives no result.
// A start or an advance gives exactly one result on the output stream (m_axis):
// the sector address, the cluster and the sector within it; tuser flags the end
// of the chain, and then the address reads zero.
// Configuration (cfg_*): index 0 is the data area start sector, index 1 the
// sectors per cluster; write only while the block is idle. cfg_ready is always high.
// A load is done in the idle state and gives no result. A start, or an advance within a
// cluster, passes through the registered multiply and the emit state to the result register;
// an advance that crosses into the next cluster first makes two reads of the table memory
// through its single read port and loads the new entry. One item is in work at a time.
// Reset clears the chain to the ended state, sectors per cluster to one and the
// data start to zero; the table memory is not cleared. When the receiver stalls,
// the result holds in the output register and input stays held off once the
// next result is ready.
module fat12_cluster_chain_sector_walker_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [39:0]                  s_axis_tdata,  // table_index, table_byte, start_cluster, pad
	input  logic [fcw_pkg::FUNC_W-1:0]   s_axis_tuser,  // func
	// master stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [55:0]                  m_axis_tdata,  // sector_lba, cluster_now, sector_in_cluster, pad
	output logic                         m_axis_tuser,  // chain_ended
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [fcw_pkg::LBA_W-1:0]    cfg_data
);
	import fcw_pkg::*;

	cmd_t                 cmd;
	stat_t                stat;
	logic [INDEX_W-1:0]   table_index;
	logic [BYTE_W-1:0]    table_byte;
	logic [CLUSTER_W-1:0] start_cluster;
	logic [LBA_W-1:0]     sector_lba;
	logic                 chain_ended;
	logic [CLUSTER_W-1:0] cluster_now;
	logic [SECTOR_W-1:0]  sector_in_cluster;

	// Unpack the input item
	assign table_index   = s_axis_tdata[12:0];
	assign table_byte    = s_axis_tdata[20:13];
	assign start_cluster = s_axis_tdata[32:21];

	assign cfg_ready = 1'b1;

	fcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.func     (s_axis_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	fcw_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.table_index       (table_index),
		.table_byte        (table_byte),
		.start_cluster     (start_cluster),
		.out_ready         (m_axis_tready),
		.out_valid         (m_axis_tvalid),
		.sector_lba        (sector_lba),
		.chain_ended       (chain_ended),
		.cluster_now       (cluster_now),
		.sector_in_cluster (sector_in_cluster)
	);

	// Pack the result item
	assign m_axis_tdata = {5'b0, sector_in_cluster, cluster_now, sector_lba};
	assign m_axis_tuser = chain_ended;

endmodule
